// ----- rtl/kaf_pkg.sv -----
// kaf_pkg: constants, register indices and op codes for the kalman angle filter
// no dependencies
package kaf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIX_W          = 32;
  localparam int NOISE_W        = 31;
  localparam int DT_W           = 16;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 31'd16777;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 31'd50332;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd503316;

  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam int SHIFT_Q16 = 16;
  localparam int SHIFT_Q24 = 24;

endpackage

// ----- rtl/kalman_angle_filter_core.sv -----
// kalman angle filter: two-state (angle, gyro bias) fixed-point kalman filter
// An update transaction makes ten passes through one shared 16-bit-per-cycle multiplier
// and two passes of a one-bit-per-cycle divider, between prediction, innovation, output
// and handoff steps. With zero innovation variance the divider is skipped. A load
// transaction goes straight to the output step. in_tready is low while a transaction is in
// flight; a result still waiting on out_tready holds the next transaction at its output step.
// Depends on kaf_pkg, kaf_mul, kaf_div.
module kalman_angle_filter_core
  import kaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,  // measured_angle[31:0], measured_rate[63:32], time_step[79:64]
  input  logic         in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // angle_estimate[31:0], unbiased_rate[63:32]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [4:0] S_IDLE = 5'd0,  S_PRED = 5'd1,  S_M1  = 5'd2,  S_M2 = 5'd3,
                         S_M3   = 5'd4,  S_M4   = 5'd5,  S_S   = 5'd6,  S_D0 = 5'd7,
                         S_D1   = 5'd8,  S_M5   = 5'd9,  S_M6  = 5'd10, S_M7 = 5'd11,
                         S_M8   = 5'd12, S_M9   = 5'd13, S_M10 = 5'd14, S_OUT = 5'd15,
                         S_WAIT = 5'd16;

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? SMIN : SMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat32(input logic signed [31:0] v);
    if (W >= 32) return W'(v);
    if (v > 32'(SMAX)) return SMAX;
    if (v < 32'(SMIN)) return SMIN;
    return W'(v);
  endfunction

  // noise registers are unsigned, clipped to the positive range of the datapath
  function automatic logic signed [W-1:0] satn(input logic [NOISE_W-1:0] v);
    if (W > NOISE_W) return W'(v);
    if (32'(v) > 32'(SMAX)) return SMAX;
    return W'(v);
  endfunction

  function automatic logic [31:0] out32(input logic signed [W-1:0] v);
    if (W <= 32) return 32'(v);
    if (v > W'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -W'(33'sh80000000)) return 32'h80000000;
    return 32'(v);
  endfunction

  logic [4:0] st_r;
  logic [NOISE_W-1:0] an_r, bn_r, mn_r;
  logic signed [W-1:0] ang_r, bias_r, rate_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [W-1:0] meas_r, dt_r, t_r, s_r, k0_r, k1_r, y_r, aa0_r, ab0_r;
  logic [63:0] out_r;
  logic ov_r, go_r;

  logic mstart, msh, mdone;
  logic signed [W-1:0] ma, mb, mres;
  logic dstart, ddone;
  logic signed [W-1:0] dnum, dquot;

  kaf_mul #(.DATA_WIDTH(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .op_a(ma), .op_b(mb), .sh24(msh),
    .done(mdone), .result(mres)
  );

  kaf_div #(.DATA_WIDTH(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(s_r),
    .done(ddone), .quot(dquot)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  // operand selection for the shared multiplier and the divider numerator
  always_comb begin
    ma = dt_r; mb = rate_r; msh = 1'b0; dnum = aa_r;
    unique case (st_r)
      S_M1:  begin ma = dt_r; mb = bb_r; end
      S_M2:  begin ma = dt_r; mb = t_r; end
      S_M3:  begin ma = satn(bn_r); mb = dt_r; end
      S_M4:  begin ma = dt_r; mb = rate_r; end
      S_D1:  dnum = ba_r;
      S_M5:  begin ma = k0_r; mb = y_r; msh = 1'b1; end
      S_M6:  begin ma = k1_r; mb = y_r; msh = 1'b1; end
      S_M7:  begin ma = k0_r; mb = aa0_r; msh = 1'b1; end
      S_M8:  begin ma = k0_r; mb = ab0_r; msh = 1'b1; end
      S_M9:  begin ma = k1_r; mb = aa0_r; msh = 1'b1; end
      S_M10: begin ma = k1_r; mb = ab0_r; msh = 1'b1; end
      default: ;
    endcase
  end

  assign mstart = go_r && (st_r == S_M1 || st_r == S_M2 || st_r == S_M3 || st_r == S_M4 ||
                  st_r == S_M5 || st_r == S_M6 || st_r == S_M7 || st_r == S_M8 ||
                  st_r == S_M9 || st_r == S_M10);
  assign dstart = go_r && (st_r == S_D0 || st_r == S_D1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; go_r <= 1'b0;
      an_r <= ANGLE_NOISE_RST; bn_r <= BIAS_NOISE_RST; mn_r <= MEASURE_NOISE_RST;
      ang_r <= '0; bias_r <= '0; rate_r <= '0;
      aa_r <= '0; ab_r <= '0; ba_r <= '0; bb_r <= '0;
    end else begin
      go_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ANGLE_NOISE:   an_r <= cfg_data;
          REG_BIAS_NOISE:    bn_r <= cfg_data;
          REG_MEASURE_NOISE: mn_r <= cfg_data;
          default: ;
        endcase
      end
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          meas_r <= sat32(in_tdata[31:0]);
          dt_r   <= W'(in_tdata[79:64]);
          if (in_tuser == OP_LOAD) begin
            ang_r <= sat32(in_tdata[31:0]);
            st_r  <= S_OUT;
          end else begin
            rate_r <= ssub(sat32(in_tdata[63:32]), bias_r);
            st_r   <= S_PRED;
          end
        end
        S_PRED: begin st_r <= S_M4; go_r <= 1'b1; end
        S_M4: if (!go_r && mdone) begin
          ang_r <= sadd(ang_r, mres); st_r <= S_M1; go_r <= 1'b1;
        end
        S_M1: if (!go_r && mdone) begin
          t_r <= sadd(ssub(ssub(mres, ab_r), ba_r), satn(an_r));
          ab_r <= ssub(ab_r, mres);
          ba_r <= ssub(ba_r, mres);
          st_r <= S_M2; go_r <= 1'b1;
        end
        S_M2: if (!go_r && mdone) begin
          aa_r <= sadd(aa_r, mres); st_r <= S_M3; go_r <= 1'b1;
        end
        S_M3: if (!go_r && mdone) begin
          bb_r <= sadd(bb_r, mres); st_r <= S_S;
        end
        S_S: begin
          s_r <= sadd(aa_r, satn(mn_r));
          y_r <= ssub(meas_r, ang_r);
          aa0_r <= aa_r; ab0_r <= ab_r;
          k0_r <= '0; k1_r <= '0;
          st_r <= S_D0; go_r <= 1'b1;
        end
        S_D0: if (s_r == '0) begin
          st_r <= S_M5; go_r <= 1'b1;
        end else if (!go_r && ddone) begin
          k0_r <= dquot; st_r <= S_D1; go_r <= 1'b1;
        end
        S_D1: if (!go_r && ddone) begin
          k1_r <= dquot; st_r <= S_M5; go_r <= 1'b1;
        end
        S_M5: if (!go_r && mdone) begin
          ang_r <= sadd(ang_r, mres); st_r <= S_M6; go_r <= 1'b1;
        end
        S_M6: if (!go_r && mdone) begin
          bias_r <= sadd(bias_r, mres); st_r <= S_M7; go_r <= 1'b1;
        end
        S_M7: if (!go_r && mdone) begin
          aa_r <= ssub(aa_r, mres); st_r <= S_M8; go_r <= 1'b1;
        end
        S_M8: if (!go_r && mdone) begin
          ab_r <= ssub(ab_r, mres); st_r <= S_M9; go_r <= 1'b1;
        end
        S_M9: if (!go_r && mdone) begin
          ba_r <= ssub(ba_r, mres); st_r <= S_M10; go_r <= 1'b1;
        end
        S_M10: if (!go_r && mdone) begin
          bb_r <= ssub(bb_r, mres); st_r <= S_OUT;
        end
        // hold here until the previous result has left the output register
        S_OUT: if (!ov_r) begin
          out_r <= {out32(rate_r), out32(ang_r)};
          st_r <= S_WAIT;
        end
        S_WAIT: begin
          ov_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/kaf_mul.sv -----
// kaf_mul: multi-cycle signed fractional multiplier, 16 bits of one operand per cycle
// depends on kaf_pkg
module kaf_mul
  import kaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic signed [DATA_WIDTH-1:0] op_b,
  input  logic                         sh24,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int CHUNKS = (DATA_WIDTH + 15) / 16;
  localparam int BW     = CHUNKS * 16;
  localparam int PW     = 2 * BW;
  localparam int CW     = $clog2(CHUNKS + 1);
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] ma_r, ma_nxt;
  logic [BW-1:0]         mb_r, mb_nxt;
  logic [PW-1:0]         acc_r, acc_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  neg_r, neg_nxt;
  logic                  sh_r, sh_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH-1:0] res_r, res_nxt;

  logic [DATA_WIDTH+15:0] part;
  logic [PW-1:0]          shifted;
  logic [PW-1:0]          lim;
  logic [DATA_WIDTH-1:0]  ua, ub;

  always_comb begin
    ua = op_a[DATA_WIDTH-1] ? DATA_WIDTH'(-op_a) : DATA_WIDTH'(op_a);
    ub = op_b[DATA_WIDTH-1] ? DATA_WIDTH'(-op_b) : DATA_WIDTH'(op_b);
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    neg_nxt = neg_r;
    sh_nxt  = sh_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    part = ma_r * mb_r[BW-1:BW-16];
    shifted = sh_r ? (acc_r >> SHIFT_Q24) : (acc_r >> SHIFT_Q16);
    lim = neg_r ? PW'(MAXV) + PW'(1) : PW'(MAXV);
    if (start) begin
      ma_nxt  = ua;
      mb_nxt  = BW'(ub);
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
      neg_nxt = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
      sh_nxt  = sh24;
    end else if (busy_r) begin
      if (cnt_r == CW'(CHUNKS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (shifted > lim) res_nxt = neg_r ? DATA_WIDTH'(-lim) : DATA_WIDTH'(lim);
        else res_nxt = neg_r ? DATA_WIDTH'(-shifted) : DATA_WIDTH'(shifted);
      end else begin
        // accumulate from the top chunk down
        acc_nxt = (acc_r << 16) + PW'(part);
        mb_nxt  = mb_r << 16;
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    sh_r  <= sh_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ----- rtl/kaf_div.sv -----
// kaf_div: restoring divider, one quotient bit per cycle, result trunc(num*2^24/den) saturated
// depends on kaf_pkg
module kaf_div
  import kaf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quot
);

  localparam int STEPS = DATA_WIDTH + SHIFT_Q24;
  localparam int SW    = $clog2(STEPS + 1);
  localparam int RW    = DATA_WIDTH + 1;
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH:0]   CAP  = {1'b0, MAXV} + (DATA_WIDTH+1)'(2);

  logic [STEPS-1:0]      n_r;
  logic [DATA_WIDTH-1:0] d_r;
  logic [RW-1:0]         rem_r;
  logic [DATA_WIDTH:0]   q_r;
  logic [SW-1:0]         cnt_r;
  logic                  busy_r, neg_r, done_r;
  logic [DATA_WIDTH-1:0] quot_r;

  logic [RW:0]         trial;
  logic                ge;
  logic [DATA_WIDTH+1:0] qsh;
  logic [DATA_WIDTH:0] lim;
  logic [DATA_WIDTH-1:0] un, ud;

  always_comb begin
    un = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
    ud = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : DATA_WIDTH'(den);
    trial = {rem_r, n_r[STEPS-1]};
    ge = (trial >= (RW+1)'(d_r));
    qsh = {q_r, ge};
    lim = neg_r ? {1'b0, MAXV} + (DATA_WIDTH+1)'(1) : {1'b0, MAXV};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == SW'(STEPS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + SW'(1);
        end
      end
    end
    if (start) begin
      n_r   <= {un, {SHIFT_Q24{1'b0}}};
      d_r   <= ud;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
    end else if (busy_r && cnt_r != SW'(STEPS)) begin
      n_r <= n_r << 1;
      if (ge) begin
        rem_r <= RW'(trial - (RW+1)'(d_r));
      end else begin
        rem_r <= RW'(trial);
      end
      q_r <= (qsh > (DATA_WIDTH+2)'(CAP)) ? CAP : qsh[DATA_WIDTH:0];
    end else if (busy_r) begin
      quot_r <= (q_r > lim) ? (neg_r ? DATA_WIDTH'(-lim) : DATA_WIDTH'(lim))
                            : (neg_r ? DATA_WIDTH'(-q_r) : DATA_WIDTH'(q_r));
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
